// ===== src/kwm_pkg.sv =====
`default_nettype none
package kwm_pkg;

    // Parameter defaults
    localparam int NUM_WAYS_DEF    = 8;
    localparam int LIST_DEPTH_DEF  = 128;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int REQ_W      = 2;
    localparam int LID_W      = 3;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 11;
    localparam int ACTIVE_W   = 4;
    localparam int OUT_VAL_W  = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 4'd8;
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;

    // Register index of active_lists (paddr[2])
    localparam logic REG_ACTIVE = 1'b0;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND  = 2'd0,
        REQ_POP     = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_INVALID = 2'd3    // unused code, answered as dropped
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_APPENDED = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_POPPED   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_CLEARED  = 3'd4
    } t_status;

endpackage
`default_nettype wire

// ===== src/kwm_ram.sv =====
`default_nettype none
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/k_way_merge_heap_top.sv =====
`default_nettype none
// Append, restart and unknown requests go straight to the result register; a pop reads
// the root, then compares the heap level by level (at most log2(NUM_WAYS) levels), and an empty
// pop is answered as empty; every heap access goes through the single read port of the heap RAM.
// The first pop after restart first gathers the head of each non-empty active list into
// the heap and sifts down each inner heap node. One request in work at a time.
// Reset (sync, active low) empties all lists, clears the merge, sets active_lists to 8.
module k_way_merge_heap_top
    import kwm_pkg::*;
#(
    parameter int NUM_WAYS    = NUM_WAYS_DEF,
    parameter int LIST_DEPTH  = LIST_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // request channel
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [kwm_pkg::REQ_W-1:0]           i_req_type,
    input  wire logic [kwm_pkg::LID_W-1:0]           i_list_id,
    input  wire logic signed [kwm_pkg::OUT_VAL_W-1:0] i_value,
    // result channel
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [kwm_pkg::STATUS_W-1:0]             o_status,
    output logic signed [kwm_pkg::OUT_VAL_W-1:0]     o_merged_value,
    output logic [kwm_pkg::LID_W-1:0]                o_source_list,
    output logic                                     o_final_flag,
    output logic [kwm_pkg::COUNT_W-1:0]              o_emitted_count,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [kwm_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [kwm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [kwm_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                     pready
);
    import kwm_pkg::*;

    localparam int LW   = $clog2(NUM_WAYS);
    localparam int EFW  = $clog2(NUM_WAYS + 1);
    localparam int HW   = $clog2(NUM_WAYS + 1);
    localparam int AW   = $clog2(NUM_WAYS * LIST_DEPTH);
    localparam int LENW = $clog2(LIST_DEPTH + 1);
    localparam int EW   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int HEW  = LW + VALUE_WIDTH;
    localparam int CW   = ((EFW > LID_W) ? EFW : LID_W) + 1;
    localparam int AXW  = ((EFW > ACTIVE_W) ? EFW : ACTIVE_W) + 1;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_BREAD  = 14'b00000000000010,
        S_BWRITE = 14'b00000000000100,
        S_SLOAD  = 14'b00000000001000,
        S_SLOADW = 14'b00000000010000,
        S_SCHK   = 14'b00000000100000,
        S_SL     = 14'b00000001000000,
        S_SR     = 14'b00000010000000,
        S_SCMP   = 14'b00000100000000,
        S_POP    = 14'b00001000000000,
        S_P1     = 14'b00010000000000,
        S_P2R    = 14'b00100000000000,
        S_P2F    = 14'b01000000000000,
        S_FIN    = 14'b10000000000000
    } t_state;

    function automatic logic sgt(input logic [VALUE_WIDTH-1:0] a,
                                 input logic [VALUE_WIDTH-1:0] b);
        sgt = $signed(a) > $signed(b);
    endfunction

    // control state
    t_state                r_state, n_state;
    logic [ACTIVE_W-1:0]   r_active;
    logic [LENW-1:0]       r_len  [NUM_WAYS];
    logic [LENW-1:0]       n_len  [NUM_WAYS];
    logic [LENW-1:0]       r_rpos [NUM_WAYS];
    logic [LENW-1:0]       n_rpos [NUM_WAYS];
    logic [HW-1:0]         r_hsize, n_hsize;
    logic                  r_started, n_started;
    logic [COUNT_W-1:0]    r_pcnt, n_pcnt;
    logic                  r_build, n_build;
    logic                  r_out_valid, n_out_valid;

    // working registers
    logic [EFW-1:0]        r_eff, n_eff;
    logic [EFW-1:0]        r_bi, n_bi;
    logic [HW-1:0]         r_bp, n_bp;
    logic [HW-1:0]         r_par, n_par;
    logic [HW:0]           r_chd, n_chd;
    logic [HW-1:0]         r_cidx, n_cidx;
    logic [HEW-1:0]        r_t, n_t;
    logic [HEW-1:0]        r_c, n_c;
    t_status               r_rstat, n_rstat;
    logic [VALUE_WIDTH-1:0] r_rval, n_rval;
    logic [LW-1:0]         r_rsrc, n_rsrc;
    logic                  r_rfin, n_rfin;

    // output register
    t_status               r_o_status;
    logic [OUT_VAL_W-1:0]  r_o_val;
    logic [LID_W-1:0]      r_o_src;
    logic                  r_o_fin;
    logic [COUNT_W-1:0]    r_o_cnt;

    // memory ports
    logic                  e_we;
    logic [AW-1:0]         e_waddr, e_raddr;
    logic [VALUE_WIDTH-1:0] e_wdata, e_rdata;
    logic                  h_we;
    logic [HW-1:0]         h_waddr, h_raddr;
    logic [HEW-1:0]        h_wdata, h_rdata;

    logic [EFW-1:0]        eff_now;
    logic [LW-1:0]         lid_ix, bi_ix, root_l;
    logic [LENW-1:0]       rpos_inc;
    logic                  app_ok;
    logic                  sift_end;
    logic                  cfg_wr;

    kwm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(NUM_WAYS * LIST_DEPTH)) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    kwm_ram #(.WIDTH(HEW), .DEPTH(NUM_WAYS + 1)) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ACTIVE);
    assign prdata = (paddr[2] == REG_ACTIVE) ? APB_DATA_W'(r_active) : '0;

    // clamp of the active list count
    always_comb begin
        if (r_active == '0) begin
            eff_now = EFW'(1);
        end else if (AXW'(r_active) > AXW'(NUM_WAYS)) begin
            eff_now = EFW'(NUM_WAYS);
        end else begin
            eff_now = EFW'(r_active);
        end
    end

    assign lid_ix   = LW'(i_list_id);
    assign bi_ix    = LW'(r_bi);
    assign root_l   = h_rdata[HEW-1 -: LW];
    assign rpos_inc = r_rpos[root_l] + LENW'(1);
    assign app_ok   = !r_started && (CW'(i_list_id) < CW'(eff_now))
                      && (r_len[lid_ix] < LENW'(LIST_DEPTH));

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_rpos      = r_rpos;
        n_hsize     = r_hsize;
        n_started   = r_started;
        n_pcnt      = r_pcnt;
        n_build     = r_build;
        n_out_valid = r_out_valid && i_stall;
        n_eff       = r_eff;
        n_bi        = r_bi;
        n_bp        = r_bp;
        n_par       = r_par;
        n_chd       = r_chd;
        n_cidx      = r_cidx;
        n_t         = r_t;
        n_c         = r_c;
        n_rstat     = r_rstat;
        n_rval      = r_rval;
        n_rsrc      = r_rsrc;
        n_rfin      = r_rfin;
        e_we        = 1'b0;
        e_waddr     = AW'(lid_ix) * AW'(LIST_DEPTH) + AW'(r_len[lid_ix]);
        e_wdata     = VALUE_WIDTH'($signed(i_value[EW-1:0]));
        e_raddr     = '0;
        h_we        = 1'b0;
        h_waddr     = r_par;
        h_wdata     = r_t;
        h_raddr     = '0;
        sift_end    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_FIN;
                    n_rstat = ST_DROPPED;
                    n_rval  = '0;
                    n_rsrc  = '0;
                    n_rfin  = 1'b0;
                    case (t_req'(i_req_type))
                        REQ_APPEND: begin
                            if (app_ok) begin
                                e_we           = 1'b1;
                                n_len[lid_ix]  = r_len[lid_ix] + LENW'(1);
                                n_rstat        = ST_APPENDED;
                            end
                        end
                        REQ_POP: begin
                            if (!r_started) begin
                                n_state = S_BREAD;
                                n_bi    = '0;
                                n_hsize = '0;
                                n_eff   = eff_now;
                            end else begin
                                n_state = S_POP;
                            end
                        end
                        REQ_RESTART: begin
                            for (int k = 0; k < NUM_WAYS; k++) begin
                                n_len[k]  = '0;
                                n_rpos[k] = '0;
                            end
                            n_hsize   = '0;
                            n_started = 1'b0;
                            n_pcnt    = '0;
                            n_rstat   = ST_CLEARED;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // gather heads of the non-empty active lists
            S_BREAD: begin
                if (r_bi == r_eff) begin
                    n_started = 1'b1;
                    if (r_hsize < HW'(2)) begin
                        n_state = S_POP;
                    end else begin
                        n_bp    = r_hsize >> 1;
                        n_par   = r_hsize >> 1;
                        n_build = 1'b1;
                        n_state = S_SLOAD;
                    end
                end else if (r_len[bi_ix] != '0) begin
                    e_raddr = AW'(bi_ix) * AW'(LIST_DEPTH);
                    n_state = S_BWRITE;
                end else begin
                    n_bi = r_bi + EFW'(1);
                end
            end

            S_BWRITE: begin
                h_we    = 1'b1;
                h_waddr = r_hsize + HW'(1);
                h_wdata = {bi_ix, e_rdata};
                n_hsize = r_hsize + HW'(1);
                n_bi    = r_bi + EFW'(1);
                n_state = S_BREAD;
            end

            // sift-down of the entry at r_par
            S_SLOAD: begin
                h_raddr = r_par;
                n_state = S_SLOADW;
            end

            S_SLOADW: begin
                n_t     = h_rdata;
                n_chd   = {r_par, 1'b0};
                n_state = S_SCHK;
            end

            S_SCHK: begin
                if (r_chd > (HW+1)'(r_hsize)) begin
                    h_we     = 1'b1;
                    sift_end = 1'b1;
                end else begin
                    h_raddr = HW'(r_chd);
                    n_state = S_SL;
                end
            end

            S_SL: begin
                n_c    = h_rdata;
                n_cidx = HW'(r_chd);
                if (r_chd < (HW+1)'(r_hsize)) begin
                    h_raddr = HW'(r_chd) + HW'(1);
                    n_state = S_SR;
                end else begin
                    n_state = S_SCMP;
                end
            end

            // right child wins only when strictly smaller
            S_SR: begin
                if (sgt(r_c[VALUE_WIDTH-1:0], h_rdata[VALUE_WIDTH-1:0])) begin
                    n_c    = h_rdata;
                    n_cidx = r_cidx + HW'(1);
                end
                n_state = S_SCMP;
            end

            S_SCMP: begin
                h_we = 1'b1;
                if (sgt(r_t[VALUE_WIDTH-1:0], r_c[VALUE_WIDTH-1:0])) begin
                    h_wdata = r_c;
                    n_par   = r_cidx;
                    n_chd   = {r_cidx, 1'b0};
                    n_state = S_SCHK;
                end else begin
                    sift_end = 1'b1;
                end
            end

            // pop
            S_POP: begin
                if (r_hsize == '0) begin
                    n_rstat = ST_EMPTY;
                    n_state = S_FIN;
                end else begin
                    h_raddr = HW'(1);
                    n_state = S_P1;
                end
            end

            S_P1: begin
                n_rstat        = ST_POPPED;
                n_rval         = h_rdata[VALUE_WIDTH-1:0];
                n_rsrc         = root_l;
                n_rpos[root_l] = rpos_inc;
                if (r_pcnt != COUNT_MAX) begin
                    n_pcnt = r_pcnt + COUNT_W'(1);
                end
                if (rpos_inc >= r_len[root_l]) begin
                    h_raddr = r_hsize;
                    n_state = S_P2R;
                end else begin
                    e_raddr = AW'(root_l) * AW'(LIST_DEPTH) + AW'(rpos_inc);
                    n_state = S_P2F;
                end
            end

            // list retired: last entry moves to the root
            S_P2R: begin
                n_t     = h_rdata;
                n_hsize = r_hsize - HW'(1);
                if (r_hsize == HW'(1)) begin
                    n_rfin  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_par   = HW'(1);
                    n_chd   = (HW+1)'(2);
                    n_build = 1'b0;
                    n_state = S_SCHK;
                end
            end

            // refill the root from the same list
            S_P2F: begin
                n_t     = {r_rsrc, e_rdata};
                n_par   = HW'(1);
                n_chd   = (HW+1)'(2);
                n_build = 1'b0;
                n_state = S_SCHK;
            end

            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // end of one sift-down
        if (sift_end) begin
            if (r_build) begin
                if (r_bp == HW'(1)) begin
                    n_build = 1'b0;
                    n_state = S_POP;
                end else begin
                    n_bp    = r_bp - HW'(1);
                    n_par   = r_bp - HW'(1);
                    n_state = S_SLOAD;
                end
            end else begin
                n_state = S_FIN;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= ACTIVE_RST;
            for (int k = 0; k < NUM_WAYS; k++) begin
                r_len[k]  <= '0;
                r_rpos[k] <= '0;
            end
            r_hsize     <= '0;
            r_started   <= 1'b0;
            r_pcnt      <= '0;
            r_build     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (cfg_wr) begin
                r_active <= pwdata[ACTIVE_W-1:0];
            end
            r_len       <= n_len;
            r_rpos      <= n_rpos;
            r_hsize     <= n_hsize;
            r_started   <= n_started;
            r_pcnt      <= n_pcnt;
            r_build     <= n_build;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_eff   <= n_eff;
        r_bi    <= n_bi;
        r_bp    <= n_bp;
        r_par   <= n_par;
        r_chd   <= n_chd;
        r_cidx  <= n_cidx;
        r_t     <= n_t;
        r_c     <= n_c;
        r_rstat <= n_rstat;
        r_rval  <= n_rval;
        r_rsrc  <= n_rsrc;
        r_rfin  <= n_rfin;
        if (r_state == S_FIN && (!r_out_valid || !i_stall)) begin
            r_o_status <= r_rstat;
            r_o_val    <= OUT_VAL_W'($signed(r_rval));
            r_o_src    <= LID_W'(r_rsrc);
            r_o_fin    <= r_rfin;
            r_o_cnt    <= r_pcnt;
        end
    end

    assign o_status        = r_o_status;
    assign o_merged_value  = r_o_val;
    assign o_source_list   = r_o_src;
    assign o_final_flag    = r_o_fin;
    assign o_emitted_count = r_o_cnt;

endmodule
`default_nettype wire

// ===== src/kwm_chk.sv =====
`default_nettype none
module kwm_chk (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_valid,
    input wire logic                                 o_stall,
    input wire logic                                 o_valid,
    input wire logic                                 i_stall,
    input wire logic [kwm_pkg::STATUS_W-1:0]         o_status,
    input wire logic signed [kwm_pkg::OUT_VAL_W-1:0] o_merged_value,
    input wire logic [kwm_pkg::LID_W-1:0]            o_source_list,
    input wire logic                                 o_final_flag,
    input wire logic [kwm_pkg::COUNT_W-1:0]          o_emitted_count
);
    import kwm_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_emitted_count))
        else $error("result changed while stalled");

    // one request in work at a time
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request taken while busy");

    // only pops carry a value, a list and a final flag
    a_nopop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_POPPED) |->
            (o_merged_value == '0) && (o_source_list == '0) && !o_final_flag)
        else $error("non-pop result carries pop fields");

    // restart zeroes the pop count
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_CLEARED) |-> (o_emitted_count == '0))
        else $error("count not cleared on restart");

endmodule

bind k_way_merge_heap_top kwm_chk u_kwm_chk (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
    import kwm_pkg::*;

    localparam int WAYS  = 8;
    localparam int DEPTH = 128;
    localparam int LIMIT = 2000000;

    // Merge scoreboard: holds the block's state and the queue of expected results
    class merge_sb;
        typedef struct packed {
            logic [STATUS_W-1:0]  status;
            logic [31:0]          value;
            logic [LID_W-1:0]     src;
            logic                 fin;
            logic [COUNT_W-1:0]   cnt;
        } t_res;

        logic [31:0] store [WAYS][DEPTH];
        int unsigned len [WAYS];
        int unsigned rpos [WAYS];
        int unsigned hl [WAYS+1];
        logic signed [31:0] hv [WAYS+1];
        int unsigned hsize;
        bit started;
        int unsigned pops;
        logic [3:0] active;
        t_res pending[$];
        int errors;
        int n_popped;
        int n_dropped;

        function void clear_state();
            for (int i = 0; i < WAYS; i++) begin
                len[i] = 0;
                rpos[i] = 0;
            end
            for (int i = 0; i <= WAYS; i++) begin
                hl[i] = 0;
                hv[i] = 0;
            end
            hsize = 0;
            started = 0;
            pops = 0;
        endfunction

        function int unsigned ways_used();
            if (active < 1) return 1;
            if (active > WAYS) return WAYS;
            return active;
        endfunction

        function void sift(int unsigned p, int unsigned n);
            int unsigned tl;
            logic signed [31:0] tv;
            int unsigned c;
            tl = hl[p];
            tv = hv[p];
            c = p * 2;
            while (c <= n) begin
                if (c < n && hv[c] > hv[c+1]) c++;
                if (tv > hv[c]) begin
                    hl[p] = hl[c];
                    hv[p] = hv[c];
                    p = c;
                    c = c * 2;
                end else begin
                    break;
                end
            end
            hl[p] = tl;
            hv[p] = tv;
        endfunction

        function void build();
            hsize = 0;
            for (int i = 0; i < ways_used(); i++) begin
                if (len[i] > 0) begin
                    hsize++;
                    hl[hsize] = i;
                    hv[hsize] = store[i][0];
                    rpos[i] = 0;
                end
            end
            for (int i = hsize / 2; i >= 1; i--) sift(i, hsize);
            started = 1;
        endfunction

        // note an accepted request and queue its result
        function void note_request(logic [1:0] rq, logic [2:0] lid, logic [31:0] val);
            t_res r;
            int unsigned l;
            r = '0;
            r.status = ST_DROPPED;
            if (rq == REQ_APPEND) begin
                if (!started && lid < ways_used() && len[lid] < DEPTH) begin
                    store[lid][len[lid]] = val;
                    len[lid]++;
                    r.status = ST_APPENDED;
                end
            end else if (rq == REQ_POP) begin
                if (!started) build();
                if (hsize == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    l = hl[1];
                    r.status = ST_POPPED;
                    r.value = hv[1];
                    r.src = LID_W'(l);
                    if (pops < 2047) pops++;
                    rpos[l]++;
                    if (rpos[l] >= len[l]) begin
                        hl[1] = hl[hsize];
                        hv[1] = hv[hsize];
                        hsize--;
                    end else begin
                        hv[1] = store[l][rpos[l]];
                    end
                    if (hsize > 0) sift(1, hsize);
                    r.fin = (hsize == 0);
                end
            end else if (rq == REQ_RESTART) begin
                clear_state();
                r.status = ST_CLEARED;
            end
            r.cnt = COUNT_W'(pops);
            pending.push_back(r);
        endfunction

        // compare one result transfer with the oldest expectation
        function void check_result(t_res got, time t);
            t_res e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", t, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.status == ST_POPPED) n_popped++;
            if (e.status == ST_DROPPED) n_dropped++;
            if (got.status !== e.status) begin
                $display("%0t: status exp %0d got %0d", t, e.status, got.status);
                errors++;
            end
            if (got.value !== e.value) begin
                $display("%0t: value exp %0d got %0d", t, $signed(e.value),
                         $signed(got.value));
                errors++;
            end
            if (got.src !== e.src) begin
                $display("%0t: source exp %0d got %0d", t, e.src, got.src);
                errors++;
            end
            if (got.fin !== e.fin) begin
                $display("%0t: final exp %0d got %0d", t, e.fin, got.fin);
                errors++;
            end
            if (got.cnt !== e.cnt) begin
                $display("%0t: count exp %0d got %0d", t, e.cnt, got.cnt);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_stall;
    logic [1:0] i_req_type = 0;
    logic [2:0] i_list_id = 0;
    logic signed [31:0] i_value = 0;
    logic o_valid;
    logic i_stall = 0;
    logic [2:0] o_status;
    logic signed [31:0] o_merged_value;
    logic [2:0] o_source_list;
    logic o_final_flag;
    logic [10:0] o_emitted_count;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;

    k_way_merge_heap_top u_dut (.*);

    always #5 i_clk = ~i_clk;

    merge_sb sb = new();
    int send_idle = 0;     // percent
    int recv_stall = 0;    // percent
    int hold_cycles = 0;
    int cycles = 0;
    int n_items = 0;

    // result side: random stall, long hold-off when requested
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall);
        end
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result({o_status, o_merged_value, o_source_list, o_final_flag,
                             o_emitted_count}, $time);
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top: errors");
            $finish;
        end
    end

    // offer one request and hold it until the transfer; valid stays up for the next one
    task automatic send(logic [1:0] rq, logic [2:0] lid, logic [31:0] val);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) @(posedge i_clk);
        end
        i_valid <= 1;
        i_req_type <= rq;
        i_list_id <= lid;
        i_value <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(rq, lid, val);
        n_items++;
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_active(logic [3:0] v);
        psel <= 1;
        pwrite <= 1;
        paddr <= 0;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.active = v;
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(3))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7fff_fffc + $urandom_range(3);
            2: return $urandom_range(40) - 20;
            default: return $urandom;
        endcase
    endfunction

    // one merge round: sorted lists appended, popped until empty, then restarted
    task automatic merge_round(int maxlen, int extra_pops);
        logic signed [31:0] cur [WAYS];
        int lens [WAYS];
        int total, w;
        total = 0;
        for (int i = 0; i < WAYS; i++) begin
            lens[i] = $urandom_range(maxlen);
            cur[i] = $signed(rand_val()) >>> 2;
        end
        for (int k = 0; k < 4 * maxlen * WAYS; k++) begin
            w = $urandom_range(WAYS - 1);
            if (lens[w] > 0) begin
                lens[w]--;
                cur[w] = cur[w] + $signed({1'b0, 4'($urandom)});
                send(REQ_APPEND, LID_W'(w), cur[w]);
                total++;
            end else if ($urandom_range(15) == 0) begin
                send($urandom_range(3) == 0 ? REQ_INVALID : REQ_APPEND, LID_W'(w), $urandom);
            end
        end
        for (int k = 0; k < total + extra_pops; k++) send(REQ_POP, 0, $urandom);
        if ($urandom_range(3) == 0) send(REQ_APPEND, LID_W'($urandom), $urandom);
        send(REQ_RESTART, LID_W'($urandom), $urandom);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        sb.active = 8;
        sb.clear_state();
        @(posedge i_clk);

        // directed: extremes, every request type, drops, empty pops, unknown type
        send(REQ_POP, 0, 0);
        send(REQ_APPEND, 0, 32'h8000_0000);
        send(REQ_APPEND, 0, 32'h7fff_ffff);
        send(REQ_APPEND, 7, 32'hffff_ffff);
        send(REQ_APPEND, 3, 32'h7fff_ffff);
        send(REQ_APPEND, 3, 32'h7fff_ffff);
        send(REQ_INVALID, 5, 32'h1234_5678);
        send(REQ_POP, 0, 0);
        send(REQ_APPEND, 2, 0);
        repeat (5) send(REQ_POP, 0, 0);
        send(REQ_POP, 0, 0);
        send(REQ_RESTART, 7, 32'hffff_ffff);
        drain();
        write_active(1);
        send(REQ_APPEND, 1, 5);
        send(REQ_APPEND, 0, -5);
        send(REQ_POP, 0, 0);
        send(REQ_POP, 0, 0);
        send(REQ_RESTART, 0, 0);
        drain();
        write_active(0);
        send(REQ_APPEND, 0, 9);
        send(REQ_POP, 0, 0);
        send(REQ_RESTART, 0, 0);
        drain();
        write_active(15);

        // full list: fill list 4 to depth and one beyond
        for (int k = 0; k <= DEPTH; k++) send(REQ_APPEND, 4, k - 64);
        send(REQ_POP, 0, 0);
        send(REQ_RESTART, 0, 0);

        // random rounds under each idling profile
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            write_active(ph == 3 ? 4'd8 : 4'($urandom_range(1, 8)));
            send_idle = (ph == 1 || ph == 3) ? 81 : 0;
            recv_stall = (ph == 2 || ph == 3) ? 81 : 0;
            if (ph == 3) begin
                send_idle = 7;
                recv_stall = 7;
            end
            if (ph == 0) hold_cycles = 300;
            for (int r = 0; r < 4; r++) begin
                merge_round($urandom_range(1, 5), $urandom_range(2));
                if (r == 1) drain();
            end
        end
        send_idle = 0;
        recv_stall = 0;
        drain();

        $display("merged %0d requests: %0d pops, %0d drops, active counts 0..15",
                 n_items, sb.n_popped, sb.n_dropped);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
